// ===== design/bxts_pkg.sv =====
// ----------------------------------------------------------------------------
// bxts_pkg: shared types and codes of the binary-XML token scanner
// Parse phases, token types, error codes and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bxts_pkg;

  typedef enum logic [2:0] {
    PH_INITIAL  = 3'd0,
    PH_NEWTOKEN = 3'd1,
    PH_NUMBER   = 3'd2,
    PH_UDATA    = 3'd3,
    PH_TAGNAME  = 3'd4,
    PH_ATTRNAME = 3'd5,
    PH_BLOB     = 3'd6,
    PH_ERROR    = 3'd7
  } bxts_phase_t;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NEST     = 3'd1;
  localparam logic [2:0] ERR_ATTR     = 3'd2;
  localparam logic [2:0] ERR_CODING   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;
  localparam logic [2:0] ERR_INTERNAL = 3'd5;

  localparam logic [2:0] TT_EXT   = 3'd0;
  localparam logic [2:0] TT_TAG   = 3'd1;
  localparam logic [2:0] TT_DTAG  = 3'd2;
  localparam logic [2:0] TT_ATTR  = 3'd3;
  localparam logic [2:0] TT_DATTR = 3'd4;
  localparam logic [2:0] TT_BLOB  = 3'd5;
  localparam logic [2:0] TT_UDATA = 3'd6;
  localparam logic [2:0] TT_NONE  = 3'd7;

  localparam logic [1:0] SUB_NONE     = 2'd0;
  localparam logic [1:0] SUB_OPEN_TAG = 2'd1;
  localparam logic [1:0] SUB_ATTR_END = 2'd3;

  typedef struct packed {
    logic        consumed;
    logic        token_valid;
    logic [2:0]  token_type;
    logic        element_done;
    logic [2:0]  error_code;
    logic [15:0] nest_depth;
    logic [31:0] token_offset;
    logic [31:0] element_offset;
  } bxts_result_t;

endpackage

`default_nettype wire

// ===== design/binary_xml_token_scanner.sv =====
// ----------------------------------------------------------------------------
// binary_xml_token_scanner: byte-serial skeleton decoder for binary XML
// An input beat passes one input register, then the scanner update into the
// result register; the updated parse state is registered alongside it.
// Throughput is one byte per cycle unless the output is back-pressured.
// Reset (rst_n low, synchronous) clears the parse state, the offsets, pause
// mode and the valid flags of both beat registers; the block is ready on the
// cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_xml_token_scanner #(
  parameter int LENGTH_BITS = 32,
  parameter int NEST_BITS   = 16,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // stream_byte[7:0]
  input  wire logic [7:0]  in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // consumed[0], token_valid[1], token_type[4:2], element_done[5],
  // error_code[8:6], nest_depth[24:9], token_offset[56:25],
  // element_offset[88:57], zero fill[95:89]
  output logic [95:0]      out_tdata
);

  logic                   pause_mode_r;
  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic                   out_valid_r;
  bxts_pkg::bxts_result_t out_res_r;
  bxts_pkg::bxts_result_t res;
  logic                   adv;

  bxts_pkg::bxts_phase_t  phase_r;
  bxts_pkg::bxts_phase_t  phase_nxt;
  logic [2:0]             err_r;
  logic [2:0]             err_nxt;
  logic [1:0]             sub_r;
  logic [1:0]             sub_nxt;
  logic [LENGTH_BITS-1:0] len_r;
  logic [LENGTH_BITS-1:0] len_nxt;
  logic [NEST_BITS-1:0]   nest_r;
  logic [NEST_BITS-1:0]   nest_nxt;
  logic [OFFSET_BITS-1:0] ofs_r;
  logic [OFFSET_BITS-1:0] ofs_nxt;
  logic [OFFSET_BITS-1:0] tok_r;
  logic [OFFSET_BITS-1:0] tok_nxt;
  logic [OFFSET_BITS-1:0] elem_r;
  logic [OFFSET_BITS-1:0] elem_nxt;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  bxts_step #(
    .LENGTH_BITS (LENGTH_BITS),
    .NEST_BITS   (NEST_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .phase       (phase_r),
    .err         (err_r),
    .sub         (sub_r),
    .len         (len_r),
    .nest        (nest_r),
    .ofs         (ofs_r),
    .tok         (tok_r),
    .elem        (elem_r),
    .stream_byte (in_byte_r),
    .pause_mode  (pause_mode_r),
    .phase_nxt   (phase_nxt),
    .err_nxt     (err_nxt),
    .sub_nxt     (sub_nxt),
    .len_nxt     (len_nxt),
    .nest_nxt    (nest_nxt),
    .ofs_nxt     (ofs_nxt),
    .tok_nxt     (tok_nxt),
    .elem_nxt    (elem_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_mode_r <= 1'b0;
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= bxts_pkg::PH_INITIAL;
      err_r        <= bxts_pkg::ERR_NONE;
      sub_r        <= bxts_pkg::SUB_NONE;
      len_r        <= '0;
      nest_r       <= '0;
      ofs_r        <= '0;
      tok_r        <= '0;
      elem_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        pause_mode_r <= cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
        in_byte_r  <= in_tdata;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
        phase_r     <= phase_nxt;
        err_r       <= err_nxt;
        sub_r       <= sub_nxt;
        len_r       <= len_nxt;
        nest_r      <= nest_nxt;
        ofs_r       <= ofs_nxt;
        tok_r       <= tok_nxt;
        elem_r      <= elem_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       out_res_r.element_offset,
                       out_res_r.token_offset,
                       out_res_r.nest_depth,
                       out_res_r.error_code,
                       out_res_r.element_done,
                       out_res_r.token_type,
                       out_res_r.token_valid,
                       out_res_r.consumed};

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bxts_pkg::PH_ERROR |=> phase_r == bxts_pkg::PH_ERROR)
    else $error("error state was left");

  a_error_code_match: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bxts_pkg::PH_ERROR) == (err_r != bxts_pkg::ERR_NONE))
    else $error("error code disagrees with parse phase");

  a_no_token_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.token_valid |-> out_res_r.token_type == bxts_pkg::TT_NONE)
    else $error("token type shown without a token");

  a_done_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.element_done |-> out_res_r.nest_depth == 16'd0
      && out_res_r.consumed)
    else $error("element completion with nonzero depth");

endmodule

`default_nettype wire

// ===== design/bxts_step.sv =====
// ----------------------------------------------------------------------------
// bxts_step: per-beat scanner update
// Computes the next parse state and the result of one stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bxts_step #(
  parameter int LENGTH_BITS = 32,
  parameter int NEST_BITS   = 16,
  parameter int OFFSET_BITS = 32
) (
  input  wire bxts_pkg::bxts_phase_t    phase,
  input  wire logic [2:0]               err,
  input  wire logic [1:0]               sub,
  input  wire logic [LENGTH_BITS-1:0]   len,
  input  wire logic [NEST_BITS-1:0]     nest,
  input  wire logic [OFFSET_BITS-1:0]   ofs,
  input  wire logic [OFFSET_BITS-1:0]   tok,
  input  wire logic [OFFSET_BITS-1:0]   elem,
  input  wire logic [7:0]               stream_byte,
  input  wire logic                     pause_mode,
  output bxts_pkg::bxts_phase_t         phase_nxt,
  output logic [2:0]                    err_nxt,
  output logic [1:0]                    sub_nxt,
  output logic [LENGTH_BITS-1:0]        len_nxt,
  output logic [NEST_BITS-1:0]          nest_nxt,
  output logic [OFFSET_BITS-1:0]        ofs_nxt,
  output logic [OFFSET_BITS-1:0]        tok_nxt,
  output logic [OFFSET_BITS-1:0]        elem_nxt,
  output bxts_pkg::bxts_result_t        res
);

  logic                   hdr;
  logic                   consumed;
  logic                   tv;
  logic [2:0]             tt;
  logic                   done;
  logic                   nest_full;
  logic [LENGTH_BITS-1:0] len_h;

  assign nest_full = &nest;

  always_comb begin
    phase_nxt = phase;
    err_nxt   = err;
    sub_nxt   = sub;
    len_nxt   = len;
    nest_nxt  = nest;
    tok_nxt   = tok;
    elem_nxt  = elem;
    hdr       = 1'b0;
    len_h     = len;
    consumed  = 1'b0;
    tv        = 1'b0;
    tt        = bxts_pkg::TT_NONE;
    done      = 1'b0;

    unique case (phase)
      bxts_pkg::PH_INITIAL, bxts_pkg::PH_NEWTOKEN: begin
        consumed = 1'b1;
        tok_nxt  = ofs;
        if (sub[1]) begin
          sub_nxt = 2'(sub - 2'd1);
        end
        if (stream_byte == 8'd0) begin
          if (nest == '0 || sub_nxt[1]) begin
            phase_nxt = bxts_pkg::PH_ERROR;
            err_nxt   = bxts_pkg::ERR_NEST;
            sub_nxt   = bxts_pkg::SUB_NONE;
          end else begin
            sub_nxt  = bxts_pkg::SUB_NONE;
            nest_nxt = NEST_BITS'(nest - NEST_BITS'(1));
            if (nest == NEST_BITS'(1)) begin
              phase_nxt = bxts_pkg::PH_INITIAL;
              done      = 1'b1;
            end
            if (pause_mode) begin
              tv = 1'b1;
            end
          end
        end else begin
          hdr       = 1'b1;
          len_h     = '0;
          phase_nxt = bxts_pkg::PH_NUMBER;
        end
      end
      bxts_pkg::PH_NUMBER: begin
        consumed = 1'b1;
        hdr      = 1'b1;
      end
      bxts_pkg::PH_UDATA, bxts_pkg::PH_TAGNAME, bxts_pkg::PH_ATTRNAME,
      bxts_pkg::PH_BLOB: begin
        if (len == '0) begin
          phase_nxt = bxts_pkg::PH_ERROR;
          err_nxt   = bxts_pkg::ERR_INTERNAL;
          sub_nxt   = bxts_pkg::SUB_NONE;
        end else begin
          consumed = 1'b1;
          len_nxt  = LENGTH_BITS'(len - LENGTH_BITS'(1));
          if (len == LENGTH_BITS'(1)) begin
            phase_nxt = bxts_pkg::PH_NEWTOKEN;
            if (phase == bxts_pkg::PH_TAGNAME) begin
              if (nest == '0) begin
                phase_nxt = bxts_pkg::PH_ERROR;
                err_nxt   = bxts_pkg::ERR_NEST;
                sub_nxt   = bxts_pkg::SUB_NONE;
              end else begin
                sub_nxt = bxts_pkg::SUB_OPEN_TAG;
              end
            end else if (phase == bxts_pkg::PH_ATTRNAME) begin
              if (nest == '0) begin
                phase_nxt = bxts_pkg::PH_ERROR;
                err_nxt   = bxts_pkg::ERR_ATTR;
                sub_nxt   = bxts_pkg::SUB_NONE;
              end else begin
                sub_nxt = bxts_pkg::SUB_ATTR_END;
              end
            end
          end
        end
      end
      bxts_pkg::PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (hdr) begin
      if (!stream_byte[7]) begin
        if (|len_h[LENGTH_BITS-1 -: 10]) begin
          phase_nxt = bxts_pkg::PH_ERROR;
          err_nxt   = bxts_pkg::ERR_OVERFLOW;
          sub_nxt   = bxts_pkg::SUB_NONE;
        end
        len_nxt = {len_h[LENGTH_BITS-8:0], stream_byte[6:0]};
      end else begin
        len_nxt = {len_h[LENGTH_BITS-5:0], stream_byte[6:3]};
        unique case (stream_byte[2:0])
          bxts_pkg::TT_EXT, bxts_pkg::TT_DTAG, bxts_pkg::TT_TAG: begin
            if (sub_nxt == bxts_pkg::SUB_OPEN_TAG) begin
              sub_nxt = bxts_pkg::SUB_NONE;
            end
            if (stream_byte[2:0] == bxts_pkg::TT_TAG) begin
              len_nxt = LENGTH_BITS'(len_nxt + LENGTH_BITS'(1));
            end
            if (nest_full) begin
              phase_nxt = bxts_pkg::PH_ERROR;
              err_nxt   = bxts_pkg::ERR_NEST;
              sub_nxt   = bxts_pkg::SUB_NONE;
            end else begin
              nest_nxt  = NEST_BITS'(nest + NEST_BITS'(1));
              elem_nxt  = tok_nxt;
              phase_nxt = bxts_pkg::PH_NEWTOKEN;
              if (stream_byte[2:0] == bxts_pkg::TT_DTAG) begin
                sub_nxt = bxts_pkg::SUB_OPEN_TAG;
              end else if (stream_byte[2:0] == bxts_pkg::TT_TAG) begin
                phase_nxt = bxts_pkg::PH_TAGNAME;
              end
            end
          end
          bxts_pkg::TT_BLOB, bxts_pkg::TT_UDATA: begin
            if (sub_nxt == bxts_pkg::SUB_OPEN_TAG) begin
              sub_nxt = bxts_pkg::SUB_NONE;
            end
            if (len_nxt == '0) begin
              phase_nxt = bxts_pkg::PH_NEWTOKEN;
            end else if (stream_byte[2:0] == bxts_pkg::TT_BLOB) begin
              phase_nxt = bxts_pkg::PH_BLOB;
            end else begin
              phase_nxt = bxts_pkg::PH_UDATA;
            end
          end
          bxts_pkg::TT_ATTR, bxts_pkg::TT_DATTR: begin
            if (sub_nxt != bxts_pkg::SUB_OPEN_TAG) begin
              phase_nxt = bxts_pkg::PH_ERROR;
              err_nxt   = bxts_pkg::ERR_ATTR;
              sub_nxt   = bxts_pkg::SUB_NONE;
            end else if (stream_byte[2:0] == bxts_pkg::TT_DATTR) begin
              sub_nxt   = bxts_pkg::SUB_ATTR_END;
              phase_nxt = bxts_pkg::PH_NEWTOKEN;
            end else begin
              len_nxt   = LENGTH_BITS'(len_nxt + LENGTH_BITS'(1));
              phase_nxt = bxts_pkg::PH_ATTRNAME;
            end
          end
          default: begin
            phase_nxt = bxts_pkg::PH_ERROR;
            err_nxt   = bxts_pkg::ERR_CODING;
            sub_nxt   = bxts_pkg::SUB_NONE;
          end
        endcase
        if (pause_mode) begin
          tv = 1'b1;
          tt = stream_byte[2:0];
        end
      end
    end

    ofs_nxt = consumed ? OFFSET_BITS'(ofs + OFFSET_BITS'(1)) : ofs;
  end

  assign res.consumed       = consumed;
  assign res.token_valid    = tv;
  assign res.token_type     = tt;
  assign res.element_done   = done;
  assign res.error_code     = err_nxt;
  assign res.nest_depth     = 16'(nest_nxt);
  assign res.token_offset   = 32'(tok_nxt);
  assign res.element_offset = 32'(elem_nxt);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the binary-XML token scanner
// Streams well-formed documents of random shape and content through the
// scanner under several back-pressure patterns and both pause-mode settings,
// then drives it into one randomly chosen error. A scoreboard predicts every
// result beat from the accepted bytes and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 10;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 380;

  class token_scan_checker;
    bit                    pause = 1'b0;
    bxts_pkg::bxts_phase_t phase = bxts_pkg::PH_INITIAL;
    logic [2:0]            err_kind = bxts_pkg::ERR_NONE;
    logic [1:0]            sub = bxts_pkg::SUB_NONE;
    logic [31:0]           remaining = '0;
    logic [15:0]           depth = '0;
    logic [31:0]           offset = '0;
    logic [31:0]           tok_start = '0;
    logic [31:0]           elem_start = '0;
    logic                  tv;
    logic [2:0]            tt;
    logic [88:0]           scans_due[$];
    int                    failures = 0;

    function int pending();
      return scans_due.size();
    endfunction

    function void raise(logic [2:0] kind);
      phase = bxts_pkg::PH_ERROR;
      err_kind = kind;
      sub = bxts_pkg::SUB_NONE;
    endfunction

    function bit open_element();
      if (depth == 16'hFFFF) begin
        raise(bxts_pkg::ERR_NEST);
        return 1'b0;
      end
      depth = depth + 16'd1;
      elem_start = tok_start;
      return 1'b1;
    endfunction

    function void header_byte(logic [7:0] b);
      logic [2:0] kind;
      if (!b[7]) begin
        if (remaining > 32'h003F_FFFF) raise(bxts_pkg::ERR_OVERFLOW);
        remaining = {remaining[24:0], b[6:0]};
        return;
      end
      remaining = {remaining[27:0], b[6:3]};
      kind = b[2:0];
      case (kind)
        bxts_pkg::TT_EXT: begin
          if (sub == bxts_pkg::SUB_OPEN_TAG) sub = bxts_pkg::SUB_NONE;
          if (open_element()) phase = bxts_pkg::PH_NEWTOKEN;
        end
        bxts_pkg::TT_DTAG: begin
          if (sub == bxts_pkg::SUB_OPEN_TAG) sub = bxts_pkg::SUB_NONE;
          if (open_element()) begin
            sub = bxts_pkg::SUB_OPEN_TAG;
            phase = bxts_pkg::PH_NEWTOKEN;
          end
        end
        bxts_pkg::TT_BLOB, bxts_pkg::TT_UDATA: begin
          if (sub == bxts_pkg::SUB_OPEN_TAG) sub = bxts_pkg::SUB_NONE;
          if (remaining == 0) phase = bxts_pkg::PH_NEWTOKEN;
          else if (kind == bxts_pkg::TT_BLOB) phase = bxts_pkg::PH_BLOB;
          else phase = bxts_pkg::PH_UDATA;
        end
        bxts_pkg::TT_DATTR: begin
          if (sub != bxts_pkg::SUB_OPEN_TAG) raise(bxts_pkg::ERR_ATTR);
          else begin
            sub = bxts_pkg::SUB_ATTR_END;
            phase = bxts_pkg::PH_NEWTOKEN;
          end
        end
        bxts_pkg::TT_ATTR: begin
          if (sub != bxts_pkg::SUB_OPEN_TAG) raise(bxts_pkg::ERR_ATTR);
          else begin
            remaining = remaining + 32'd1;
            phase = bxts_pkg::PH_ATTRNAME;
          end
        end
        bxts_pkg::TT_TAG: begin
          if (sub == bxts_pkg::SUB_OPEN_TAG) sub = bxts_pkg::SUB_NONE;
          remaining = remaining + 32'd1;
          if (open_element()) phase = bxts_pkg::PH_TAGNAME;
        end
        default: raise(bxts_pkg::ERR_CODING);
      endcase
      if (pause) begin
        tv = 1'b1;
        tt = kind;
      end
    endfunction

    function void scan_byte(logic [7:0] b);
      logic used;
      logic done;
      used = 1'b0;
      done = 1'b0;
      tv = 1'b0;
      tt = bxts_pkg::TT_NONE;
      case (phase)
        bxts_pkg::PH_INITIAL, bxts_pkg::PH_NEWTOKEN: begin
          used = 1'b1;
          tok_start = offset;
          if (sub > bxts_pkg::SUB_OPEN_TAG) sub = sub - 2'd1;
          if (b == 8'h00) begin
            if (depth == 0 || sub > bxts_pkg::SUB_OPEN_TAG) raise(bxts_pkg::ERR_NEST);
            else begin
              if (sub == bxts_pkg::SUB_OPEN_TAG) sub = bxts_pkg::SUB_NONE;
              depth = depth - 16'd1;
              if (depth == 0) begin
                phase = bxts_pkg::PH_INITIAL;
                done = 1'b1;
              end
              if (pause) begin
                tv = 1'b1;
                tt = bxts_pkg::TT_NONE;
              end
            end
          end else begin
            remaining = '0;
            phase = bxts_pkg::PH_NUMBER;
            header_byte(b);
          end
        end
        bxts_pkg::PH_NUMBER: begin
          used = 1'b1;
          header_byte(b);
        end
        bxts_pkg::PH_TAGNAME, bxts_pkg::PH_ATTRNAME, bxts_pkg::PH_UDATA,
        bxts_pkg::PH_BLOB: begin
          if (remaining == 0) raise(bxts_pkg::ERR_INTERNAL);
          else begin
            used = 1'b1;
            remaining = remaining - 32'd1;
            if (remaining == 0) begin
              if (phase == bxts_pkg::PH_TAGNAME && depth == 0) raise(bxts_pkg::ERR_NEST);
              else if (phase == bxts_pkg::PH_ATTRNAME && depth == 0)
                raise(bxts_pkg::ERR_ATTR);
              else begin
                if (phase == bxts_pkg::PH_TAGNAME) sub = bxts_pkg::SUB_OPEN_TAG;
                else if (phase == bxts_pkg::PH_ATTRNAME) sub = bxts_pkg::SUB_ATTR_END;
                phase = bxts_pkg::PH_NEWTOKEN;
              end
            end
          end
        end
        default: ;
      endcase
      if (used) offset = offset + 32'd1;
      scans_due.push_back({elem_start, tok_start, depth, err_kind, done, tt, tv, used});
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      failures++;
      if (failures <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endfunction

    function void check_result(logic [95:0] beat);
      logic [88:0] want;
      if (scans_due.size() == 0) begin
        report("unexpected result beat", '0, beat[31:0]);
        return;
      end
      want = scans_due.pop_front();
      if (beat[0] !== want[0]) report("consumed", want[0], beat[0]);
      if (beat[1] !== want[1]) report("token_valid", want[1], beat[1]);
      if (beat[4:2] !== want[4:2]) report("token_type", want[4:2], beat[4:2]);
      if (beat[5] !== want[5]) report("element_done", want[5], beat[5]);
      if (beat[8:6] !== want[8:6]) report("error_code", want[8:6], beat[8:6]);
      if (beat[24:9] !== want[24:9]) report("nest_depth", want[24:9], beat[24:9]);
      if (beat[56:25] !== want[56:25]) report("token_offset", want[56:25], beat[56:25]);
      if (beat[88:57] !== want[88:57]) report("element_offset", want[88:57], beat[88:57]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  logic [7:0]  byte_stream[$];

  token_scan_checker scan_check = new();

  binary_xml_token_scanner dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) scan_check.scan_byte(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) scan_check.check_result(out_tdata);
  end

  function automatic logic [31:0] rand_value();
    return $urandom >> $urandom_range(31);
  endfunction

  function automatic int body_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
  endfunction

  function automatic void put_header(logic [2:0] kind, logic [31:0] value);
    logic [7:0]  digits[$];
    logic [31:0] rest;
    rest = value >> 4;
    while (rest != 0) begin
      digits.push_front({1'b0, rest[6:0]});
      rest = rest >> 7;
    end
    foreach (digits[i]) byte_stream.push_back(digits[i]);
    byte_stream.push_back({1'b1, value[3:0], kind});
  endfunction

  function automatic void put_body(int n);
    repeat (n) byte_stream.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_data(logic [2:0] kind);
    int n;
    n = body_len();
    put_header(kind, n);
    put_body(n);
  endfunction

  function automatic void gen_element(int level);
    int opener;
    int n;
    opener = $urandom_range(2);
    case (opener)
      0: begin
        n = $urandom_range(4, 1);
        put_header(bxts_pkg::TT_TAG, n - 1);
        put_body(n);
      end
      1: put_header(bxts_pkg::TT_DTAG, rand_value());
      default: put_header(bxts_pkg::TT_EXT, rand_value());
    endcase
    if (opener != 2) begin
      repeat ($urandom_range(2)) begin
        if ($urandom_range(1)) begin
          n = $urandom_range(3, 1);
          put_header(bxts_pkg::TT_ATTR, n - 1);
          put_body(n);
        end else begin
          put_header(bxts_pkg::TT_DATTR, rand_value());
        end
        put_data(bxts_pkg::TT_UDATA);
      end
    end
    repeat ((level < 3) ? $urandom_range(3) : 0) begin
      case ($urandom_range(2))
        0: gen_element(level + 1);
        1: put_data(bxts_pkg::TT_UDATA);
        default: put_data(bxts_pkg::TT_BLOB);
      endcase
    end
    byte_stream.push_back(8'h00);
  endfunction

  task automatic write_pause(input bit value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scan_check.pause = value;
  endtask

  task automatic send_stream_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic run_phase(input bit pause, input int send_idle, input int stall,
                           input int items);
    write_pause(pause);
    send_idle_pct = send_idle;
    stall_pct = stall;
    while (byte_stream.size() < items) begin
      if ($urandom_range(7) == 0)
        put_data($urandom_range(1) ? bxts_pkg::TT_UDATA : bxts_pkg::TT_BLOB);
      else gen_element(0);
    end
    foreach (byte_stream[i]) send_stream_byte(byte_stream[i]);
    byte_stream.delete();
    in_tvalid <= 1'b0;
    while (scan_check.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    bit last_pause;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-built document: every token type, extreme header values and
    // body bytes, empty bodies and a return to depth zero.
    put_header(bxts_pkg::TT_TAG, 1);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'hFF);
    put_header(bxts_pkg::TT_DATTR, 32'hFFFF_FFFF);
    put_header(bxts_pkg::TT_UDATA, 0);
    put_header(bxts_pkg::TT_ATTR, 0);
    byte_stream.push_back(8'h80);
    put_header(bxts_pkg::TT_UDATA, 1);
    byte_stream.push_back(8'h7F);
    put_header(bxts_pkg::TT_EXT, 0);
    put_header(bxts_pkg::TT_BLOB, 1);
    byte_stream.push_back(8'hFF);
    byte_stream.push_back(8'h00);
    put_header(bxts_pkg::TT_DTAG, 32'hFFFF_FFFF);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'h00);
    put_header(bxts_pkg::TT_BLOB, 0);
    put_header(bxts_pkg::TT_UDATA, 2);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'hFF);

    run_phase(1'b1, 0, 0, PHASE_ITEMS);
    run_phase(1'b0, 87, 0, PHASE_ITEMS);
    run_phase(1'b1, 0, 87, PHASE_ITEMS);
    run_phase(1'b0, 30, 30, PHASE_ITEMS);
    last_pause = 1'($urandom_range(1));
    run_phase(last_pause, 30, 30, PHASE_ITEMS);

    // The error state only clears on reset, so each run ends in one fault.
    case ($urandom_range(5))
      0: byte_stream.push_back(8'h00);
      1: begin
        put_header(bxts_pkg::TT_DTAG, rand_value());
        put_header(bxts_pkg::TT_DATTR, rand_value());
        byte_stream.push_back(8'h00);
      end
      2: put_header(bxts_pkg::TT_ATTR, rand_value());
      // Type seven is not a valid token type.
      3: put_header(bxts_pkg::TT_NONE, rand_value());
      4: repeat (5) byte_stream.push_back(8'h7F);
      default: begin
        if ($urandom_range(1)) begin
          put_header(bxts_pkg::TT_DTAG, rand_value());
          put_header(bxts_pkg::TT_ATTR, 32'hFFFF_FFFF);
        end else begin
          put_header(bxts_pkg::TT_TAG, 32'hFFFF_FFFF);
        end
      end
    endcase
    put_body(8);
    run_phase(last_pause, 30, 30, 0);

    if (scan_check.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
